// File: sv/sms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multimode semaphore package
// Shared codes, field widths and the result flag group for the semaphore unit.
// ----------------------------------------------------------------------------
package sms_pkg;

    // Field widths that the interface fixes.
    localparam int KIND_WIDTH   = 3;
    localparam int MODE_WIDTH   = 3;
    localparam int AMOUNT_WIDTH = 16;

    // Defaults for the top-level parameters.
    localparam int ID_WIDTH_DEF    = 16;
    localparam int COUNT_WIDTH_DEF = 17;

    // Status written by a close, before saturation.
    localparam int CLOSE_STATUS = 65535;

    // Request kinds. Codes five to seven are not defined.
    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_TAKE  = 3'd0,
        KIND_SET   = 3'd1,
        KIND_RESET = 3'd2,
        KIND_OPEN  = 3'd3,
        KIND_CLOSE = 3'd4
    } kind_t;

    // Rule sets selected at open. Codes five to seven are not defined.
    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_LATCH = 3'd0,
        MODE_AUTO  = 3'd1,
        MODE_COUNT = 3'd2,
        MODE_MULTI = 3'd3,
        MODE_MUTEX = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ERR_OK          = 2'd0,
        ERR_ILLEGAL     = 2'd1,
        ERR_INVALID     = 2'd2,
        ERR_UNSUPPORTED = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        EVENT_NONE  = 2'd0,
        EVENT_WAKE  = 2'd1,
        EVENT_BLOCK = 2'd2
    } event_t;

    // Flags of one result, passed from the core to the output register.
    typedef struct packed {
        logic   granted;
        err_t   err;
        event_t gate_event;
    } result_flags_t;

endpackage : sms_pkg
`default_nettype wire

// File: sv/sms_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request input register
// Holds one accepted request until the core consumes it; another is taken
// in the same cycle it moves on, so requests flow every cycle unless stalled.
// ----------------------------------------------------------------------------
module sms_in_reg
    import sms_pkg::*;
#(
    parameter int DATA_W = KIND_WIDTH + ID_WIDTH_DEF + AMOUNT_WIDTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [DATA_W-1:0] s_data,
    input  wire logic              consume,
    output logic                   valid,
    output logic [DATA_W-1:0]      data
);

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;

    // Room for a request when empty or when the held one leaves this cycle.
    assign s_ready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule : sms_in_reg
`default_nettype wire

// File: sv/sms_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Semaphore core
// Holds the open flag, the latched mode, the status count and the mutex owner,
// and works out one request's result and next state in a single pass.
// ----------------------------------------------------------------------------
module sms_core
    import sms_pkg::*;
#(
    parameter int ID_WIDTH    = ID_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [MODE_WIDTH-1:0]   sem_mode,
    input  wire logic                    fire,
    input  wire logic [KIND_WIDTH-1:0]   kind,
    input  wire logic [ID_WIDTH-1:0]     requester,
    input  wire logic [AMOUNT_WIDTH-1:0] amount,
    output result_flags_t                flags,
    output logic [COUNT_WIDTH-1:0]       status_now
);

    // Wide enough for the status plus a 16-bit amount without overflow.
    localparam int SW = ((COUNT_WIDTH > AMOUNT_WIDTH + 1) ? COUNT_WIDTH : AMOUNT_WIDTH + 1) + 2;

    localparam logic signed [SW-1:0] ONE_W      = SW'(1);
    localparam logic signed [SW-1:0] STAT_MAX_W =
        SW'((64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] STAT_MIN_W = -STAT_MAX_W - ONE_W;
    localparam logic signed [SW-1:0] CLOSE_W    = SW'(CLOSE_STATUS);
    localparam logic signed [COUNT_WIDTH-1:0] ZERO_S = '0;
    localparam logic signed [COUNT_WIDTH-1:0] ONE_S  = COUNT_WIDTH'(1);

    // Saturate a wide signed value into the status range.
    function automatic logic signed [COUNT_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [COUNT_WIDTH-1:0] r;
        if (v > STAT_MAX_W) begin
            r = STAT_MAX_W[COUNT_WIDTH-1:0];
        end else if (v < STAT_MIN_W) begin
            r = STAT_MIN_W[COUNT_WIDTH-1:0];
        end else begin
            r = v[COUNT_WIDTH-1:0];
        end
        return r;
    endfunction

    logic                          open_reg;
    logic                          open_next;
    mode_t                         mode_reg;
    mode_t                         mode_next;
    logic signed [COUNT_WIDTH-1:0] status_reg;
    logic signed [COUNT_WIDTH-1:0] status_next;
    logic [ID_WIDTH-1:0]           owner_reg;
    logic [ID_WIDTH-1:0]           owner_next;

    logic signed [SW-1:0]          stat_ext;
    logic signed [SW-1:0]          amt_ext;
    logic signed [COUNT_WIDTH-1:0] st_inc;
    logic signed [COUNT_WIDTH-1:0] st_dec;
    logic signed [COUNT_WIDTH-1:0] st_add;
    logic signed [COUNT_WIDTH-1:0] st_multi_reset;
    logic signed [COUNT_WIDTH-1:0] st_close;
    logic signed [COUNT_WIDTH-1:0] st_mutex_set;
    logic                          available;
    logic                          was_locked;
    logic                          now_locked;
    logic                          mode_known;
    logic                          track;
    logic                          granted;
    err_t                          err;
    event_t                        gate_event;

    // Candidate status values, each saturated.
    assign stat_ext       = SW'(status_reg);
    assign amt_ext        = SW'({1'b0, amount});
    assign st_inc         = sat(stat_ext + ONE_W);
    assign st_dec         = sat(stat_ext - ONE_W);
    assign st_add         = sat(stat_ext + amt_ext);
    assign st_multi_reset = sat(ONE_W - amt_ext);
    assign st_close       = sat(CLOSE_W);

    assign available    = status_reg > ZERO_S;
    assign was_locked   = !available;
    assign mode_known   = mode_reg <= MODE_MUTEX;
    assign st_mutex_set = available ? status_reg : st_inc;

    // Next state and result for the request at the core input.
    always_comb begin
        open_next   = open_reg;
        mode_next   = mode_reg;
        status_next = status_reg;
        owner_next  = owner_reg;
        granted     = 1'b0;
        err         = ERR_OK;
        gate_event  = EVENT_NONE;
        track       = 1'b0;
        case (kind_t'(kind))
            KIND_TAKE: begin
                if (!open_reg || !mode_known) begin
                    err = ERR_UNSUPPORTED;
                end else begin
                    track = 1'b1;
                    case (mode_reg)
                        MODE_LATCH, MODE_MULTI: begin
                            granted = available;
                        end
                        MODE_AUTO: begin
                            if (available) begin
                                granted     = 1'b1;
                                status_next = ZERO_S;
                            end
                        end
                        MODE_COUNT: begin
                            if (available) begin
                                granted     = 1'b1;
                                status_next = st_dec;
                            end
                        end
                        MODE_MUTEX: begin
                            if (available) begin
                                // Free mutex: the requester becomes the owner.
                                granted     = 1'b1;
                                status_next = ZERO_S;
                                owner_next  = requester;
                            end else if (requester == owner_reg) begin
                                // Owner takes one more recursive level.
                                granted     = 1'b1;
                                status_next = st_dec;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            KIND_SET: begin
                if (!open_reg || !mode_known) begin
                    err = ERR_UNSUPPORTED;
                end else begin
                    track = 1'b1;
                    case (mode_reg)
                        MODE_LATCH, MODE_AUTO: begin
                            status_next = ONE_S;
                        end
                        MODE_MULTI: begin
                            if (!available) begin
                                status_next = st_inc;
                            end
                        end
                        MODE_COUNT: begin
                            status_next = st_add;
                        end
                        MODE_MUTEX: begin
                            if (requester != owner_reg) begin
                                err = ERR_ILLEGAL;
                            end else begin
                                // Releasing the last level frees the owner.
                                status_next = st_mutex_set;
                                if (st_mutex_set == ONE_S) begin
                                    owner_next = '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            KIND_RESET: begin
                track = 1'b1;
                if (open_reg && mode_reg == MODE_MULTI) begin
                    status_next = st_multi_reset;
                end else if (open_reg && mode_reg == MODE_MUTEX) begin
                    err = ERR_INVALID;
                end else begin
                    status_next = ZERO_S;
                end
            end
            KIND_OPEN: begin
                if (open_reg) begin
                    err = ERR_ILLEGAL;
                end else begin
                    open_next = 1'b1;
                    mode_next = mode_t'(sem_mode);
                    if (mode_t'(sem_mode) == MODE_MUTEX) begin
                        status_next = ONE_S;
                        owner_next  = '0;
                    end
                end
            end
            KIND_CLOSE: begin
                if (!open_reg) begin
                    err = ERR_INVALID;
                end else begin
                    status_next = st_close;
                    open_next   = 1'b0;
                    if (was_locked && st_close > ZERO_S) begin
                        gate_event = EVENT_WAKE;
                    end
                end
            end
            default: begin
                err = ERR_UNSUPPORTED;
            end
        endcase

        // Report a change of availability for successful take, set and reset.
        now_locked = status_next <= ZERO_S;
        if (track && err == ERR_OK && now_locked != was_locked) begin
            gate_event = now_locked ? EVENT_BLOCK : EVENT_WAKE;
        end
    end

    // State registers advance only when the request moves to the result stage.
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            open_reg   <= 1'b0;
            mode_reg   <= MODE_LATCH;
            status_reg <= ZERO_S;
            owner_reg  <= '0;
        end else if (fire) begin
            open_reg   <= open_next;
            mode_reg   <= mode_next;
            status_reg <= status_next;
            owner_reg  <= owner_next;
        end
    end

    assign flags.granted    = granted;
    assign flags.err        = err;
    assign flags.gate_event = gate_event;
    assign status_now       = status_next;

endmodule : sms_core
`default_nettype wire

// File: sv/sms_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result output register
// Holds one result for the downstream side and packs it into the bus word.
// It reloads in the same cycle that the held result is taken.
// ----------------------------------------------------------------------------
module sms_out_reg
    import sms_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int DATA_W      = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  result_flags_t               flags,
    input  wire logic [COUNT_WIDTH-1:0] status_now,
    output logic                        can_load,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [DATA_W-1:0]           m_data
);

    logic                   valid_reg;
    logic                   valid_next;
    result_flags_t          flags_reg;
    logic [COUNT_WIDTH-1:0] status_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            flags_reg  <= flags;
            status_reg <= status_now;
        end
    end

    // Pack from the lowest bit: granted, error code, status, gate event.
    assign m_valid = valid_reg;
    assign m_data  = DATA_W'({flags_reg.gate_event, status_reg, flags_reg.err,
                              flags_reg.granted});

endmodule : sms_out_reg
`default_nettype wire

// File: sv/multimode_semaphore_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multimode semaphore unit
// Semaphore and recursive mutex with open, close, take, set and reset requests.
// ----------------------------------------------------------------------------
// The unit accepts one request per clock cycle and returns exactly one result
// for each, in order. A request is held in the input register; the status
// logic then computes its result and the new state in a single pass, and the
// result is loaded into the output register once that register has room.
// Results back up into the input register and then stall the input when the
// output side does not take them. The mode register is sampled by an open
// request and should be written only while no request is in flight; the write
// port is always ready. The status count is signed COUNT_WIDTH bits and
// saturates at both ends; a take never blocks and simply reports whether it
// was granted.
// ----------------------------------------------------------------------------
module multimode_semaphore_unit
    import sms_pkg::*;
#(
    parameter int ID_WIDTH    = ID_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Mode register write
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [MODE_WIDTH-1:0] cfg_data,
    // Request channel
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata from bit 0: requester, amount, zero fill
    input  wire logic [((ID_WIDTH + AMOUNT_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: kind
    input  wire logic [KIND_WIDTH-1:0] s_axis_tuser,
    // Result channel
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata from bit 0: granted, error_code, status_now, gate_event, zero fill
    output logic [((COUNT_WIDTH + 5 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int IN_W    = KIND_WIDTH + ID_WIDTH + AMOUNT_WIDTH;
    localparam int M_DATA_W = ((COUNT_WIDTH + 5 + 7) / 8) * 8;
    localparam int ID_LO   = KIND_WIDTH;
    localparam int AMT_LO  = KIND_WIDTH + ID_WIDTH;

    logic [MODE_WIDTH-1:0] sem_mode_reg;
    logic [IN_W-1:0]       req_in;
    logic [IN_W-1:0]       req_data;
    logic                  req_valid;
    logic                  out_can_load;
    logic                  advance;
    result_flags_t         flags;
    logic [COUNT_WIDTH-1:0] status_now;

    // Mode register, written on every completed write request.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sem_mode_reg <= MODE_LATCH;
        end else if (cfg_valid && cfg_ready) begin
            sem_mode_reg <= cfg_data;
        end
    end

    // Input register holds the kind, requester and amount.
    assign req_in = {s_axis_tdata[ID_WIDTH + AMOUNT_WIDTH - 1:ID_WIDTH],
                     s_axis_tdata[ID_WIDTH-1:0], s_axis_tuser};

    sms_in_reg #(
        .DATA_W (IN_W)
    ) u_in_reg (
        .clk     (aclk),
        .rst_n   (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (req_in),
        .consume (advance),
        .valid   (req_valid),
        .data    (req_data)
    );

    // The held request moves on whenever the output register has room.
    assign advance = req_valid && out_can_load;

    sms_core #(
        .ID_WIDTH    (ID_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (aclk),
        .rst_n      (aresetn),
        .sem_mode   (sem_mode_reg),
        .fire       (advance),
        .kind       (req_data[KIND_WIDTH-1:0]),
        .requester  (req_data[AMT_LO-1:ID_LO]),
        .amount     (req_data[IN_W-1:AMT_LO]),
        .flags      (flags),
        .status_now (status_now)
    );

    sms_out_reg #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .DATA_W      (M_DATA_W)
    ) u_out_reg (
        .clk        (aclk),
        .rst_n      (aresetn),
        .load       (advance),
        .flags      (flags),
        .status_now (status_now),
        .can_load   (out_can_load),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata)
    );

    // Every request that leaves the input register shows up as a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_axis_tvalid)
        else $error("Request advanced without producing a result.");

    // A granted take never reports an error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && flags.granted) |-> (flags.err == ERR_OK))
        else $error("Grant reported together with an error.");

    // A failed request reports no gate event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && flags.err != ERR_OK) |-> (flags.gate_event == EVENT_NONE))
        else $error("Gate event reported on a failed request.");

    // Input stalls only while a request is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> req_valid)
        else $error("Input stalled with an empty input register.");

endmodule : multimode_semaphore_unit
`default_nettype wire

// File: bench/tb_multimode_semaphore_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multimode semaphore unit testbench
// Drives request streams through the unit and checks every result against an
// in-bench semaphore model. A short directed part covers the closed state,
// latching, counting and mutex rules, saturation and undefined codes. Random
// sessions then follow under changing stall patterns on both streams.
// ----------------------------------------------------------------------------
module tb_multimode_semaphore_unit;
    import sms_pkg::*;

    localparam int ID_W          = ID_WIDTH_DEF;
    localparam int COUNT_W       = COUNT_WIDTH_DEF;
    localparam int S_DATA_W      = ((ID_W + AMOUNT_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W      = ((COUNT_W + 5 + 7) / 8) * 8;
    localparam int LEVEL_MAX     = (1 << (COUNT_W - 1)) - 1;
    localparam int LEVEL_MIN     = -(1 << (COUNT_W - 1));
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT  = 10;
    localparam int PER_MODE      = 85;

    // Codes that the package leaves undefined.
    localparam logic [KIND_WIDTH-1:0] KIND_UNDEFINED = 3'd7;
    localparam logic [MODE_WIDTH-1:0] MODE_UNDEFINED = 3'd7;

    typedef struct {
        logic                      granted;
        err_t                      err;
        logic signed [COUNT_W-1:0] status;
        event_t                    gate_event;
    } outcome_t;

    // Clock, reset and stream signals; those the bench drives are known from time zero.
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [MODE_WIDTH-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata from bit 0: requester, amount, zero fill
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    // tuser: kind
    logic [KIND_WIDTH-1:0] s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata from bit 0: granted, error_code, status_now, gate_event, zero fill
    logic [M_DATA_W-1:0]   m_axis_tdata;

    // Semaphore model state.
    bit                    sem_is_open = 1'b0;
    logic [MODE_WIDTH-1:0] sem_rules   = MODE_LATCH;
    int                    sem_level   = 0;
    logic [ID_W-1:0]       sem_owner   = '0;
    logic [MODE_WIDTH-1:0] mode_reg    = MODE_LATCH;

    outcome_t awaited_outcomes[$];
    outcome_t seen_outcome;
    outcome_t want_outcome;

    int send_idle_pct = 0;
    int rcv_stall_pct = 0;
    int stall_request = 0;
    int hold_left     = 0;

    int fail_count    = 0;
    int checked_count = 0;
    int grant_count   = 0;
    int wake_count    = 0;
    int block_count   = 0;
    int mode_writes   = 0;
    int kind_count[8];

    multimode_semaphore_unit #(
        .ID_WIDTH    (ID_W),
        .COUNT_WIDTH (COUNT_W)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Semaphore model
    // ------------------------------------------------------------------------
    function automatic int saturate_level(input int v);
        if (v > LEVEL_MAX) return LEVEL_MAX;
        if (v < LEVEL_MIN) return LEVEL_MIN;
        return v;
    endfunction

    // Applies one request to the model state and returns its result.
    function automatic outcome_t semaphore_outcome(input logic [KIND_WIDTH-1:0] k,
                                                   input logic [ID_W-1:0] who,
                                                   input logic [AMOUNT_WIDTH-1:0] amt);
        outcome_t r;
        bit was_locked;
        bit track;
        bit rules_ok;
        r.granted    = 1'b0;
        r.err        = ERR_OK;
        r.gate_event = EVENT_NONE;
        was_locked   = (sem_level <= 0);
        track        = 1'b0;
        rules_ok     = sem_is_open && (sem_rules <= MODE_MUTEX);
        case (k)
            KIND_TAKE: begin
                if (!rules_ok) begin
                    r.err = ERR_UNSUPPORTED;
                end else begin
                    track = 1'b1;
                    case (sem_rules)
                        MODE_LATCH, MODE_MULTI: begin
                            r.granted = (sem_level > 0);
                        end
                        MODE_AUTO: begin
                            if (sem_level > 0) begin
                                r.granted = 1'b1;
                                sem_level = 0;
                            end
                        end
                        MODE_COUNT: begin
                            if (sem_level > 0) begin
                                r.granted = 1'b1;
                                sem_level = saturate_level(sem_level - 1);
                            end
                        end
                        default: begin
                            // Recursive mutex: a free mutex goes to the caller,
                            // a held one only nests for its owner.
                            if (sem_level <= 0) begin
                                if (who == sem_owner) begin
                                    r.granted = 1'b1;
                                    sem_level = saturate_level(sem_level - 1);
                                end
                            end else begin
                                r.granted = 1'b1;
                                sem_level = 0;
                                sem_owner = who;
                            end
                        end
                    endcase
                end
            end
            KIND_SET: begin
                if (!rules_ok) begin
                    r.err = ERR_UNSUPPORTED;
                end else begin
                    track = 1'b1;
                    case (sem_rules)
                        MODE_LATCH, MODE_AUTO: begin
                            sem_level = saturate_level(1);
                        end
                        MODE_MULTI: begin
                            if (sem_level <= 0) sem_level = saturate_level(sem_level + 1);
                        end
                        MODE_COUNT: begin
                            sem_level = saturate_level(sem_level + int'(amt));
                        end
                        default: begin
                            if (who != sem_owner) begin
                                r.err = ERR_ILLEGAL;
                            end else begin
                                if (sem_level <= 0) sem_level = saturate_level(sem_level + 1);
                                if (sem_level == 1) sem_owner = '0;
                            end
                        end
                    endcase
                end
            end
            KIND_RESET: begin
                track = 1'b1;
                if (sem_is_open && sem_rules == MODE_MULTI) begin
                    sem_level = saturate_level(1 - int'(amt));
                end else if (sem_is_open && sem_rules == MODE_MUTEX) begin
                    r.err = ERR_INVALID;
                end else begin
                    sem_level = 0;
                end
            end
            KIND_OPEN: begin
                if (sem_is_open) begin
                    r.err = ERR_ILLEGAL;
                end else begin
                    sem_is_open = 1'b1;
                    sem_rules   = mode_reg;
                    if (sem_rules == MODE_MUTEX) begin
                        sem_level = saturate_level(1);
                        sem_owner = '0;
                    end
                end
            end
            KIND_CLOSE: begin
                if (!sem_is_open) begin
                    r.err = ERR_INVALID;
                end else begin
                    sem_level   = saturate_level(CLOSE_STATUS);
                    sem_is_open = 1'b0;
                    if (was_locked && sem_level > 0) r.gate_event = EVENT_WAKE;
                end
            end
            default: begin
                r.err = ERR_UNSUPPORTED;
            end
        endcase
        // Availability change for take, set and reset.
        if (track && r.err == ERR_OK && ((sem_level <= 0) != was_locked)) begin
            r.gate_event = (sem_level <= 0) ? EVENT_BLOCK : EVENT_WAKE;
        end
        r.status = sem_level[COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stream helpers
    // ------------------------------------------------------------------------

    // Offers one request, with random idle cycles ahead of it, and records
    // the predicted result once the unit has accepted it.
    task automatic issue_request(input logic [KIND_WIDTH-1:0] k,
                                 input logic [ID_W-1:0] who,
                                 input logic [AMOUNT_WIDTH-1:0] amt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= S_DATA_W'({amt, who});
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        awaited_outcomes.push_back(semaphore_outcome(k, who, amt));
        kind_count[k]++;
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_outcomes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The mode register is only written with nothing in flight.
    task automatic write_mode(input logic [MODE_WIDTH-1:0] m);
        drain();
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        mode_reg = m;
        mode_writes++;
    endtask

    // Picks a request that mostly follows a sensible session: open when
    // closed, then takes and sets with some resets, closes and stray opens.
    task automatic random_request(output logic [KIND_WIDTH-1:0] k,
                                  output logic [ID_W-1:0] who,
                                  output logic [AMOUNT_WIDTH-1:0] amt);
        int pick;
        pick = $urandom_range(99);
        if (!sem_is_open) begin
            k = (pick < 70) ? KIND_OPEN : KIND_WIDTH'($urandom_range(KIND_CLOSE));
        end else if (pick < 40) begin
            k = KIND_TAKE;
        end else if (pick < 70) begin
            k = KIND_SET;
        end else if (pick < 84) begin
            k = KIND_RESET;
        end else if (pick < 90) begin
            k = KIND_CLOSE;
        end else begin
            k = KIND_WIDTH'($urandom_range(KIND_CLOSE));
        end
        // A small pool of callers keeps mutex ownership meaningful.
        pick = $urandom_range(99);
        if (pick < 50)      who = ID_W'($urandom_range(3, 1));
        else if (pick < 60) who = '1;
        else                who = ID_W'($urandom_range(65535, 1));
        pick = $urandom_range(99);
        if (pick < 50)      amt = AMOUNT_WIDTH'($urandom_range(3));
        else if (pick < 60) amt = '1;
        else if (pick < 70) amt = '0;
        else                amt = AMOUNT_WIDTH'($urandom_range(65535));
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_request > 0) begin
            hold_left     = stall_request;
            stall_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen_outcome.granted    = m_axis_tdata[0];
            seen_outcome.err        = err_t'(m_axis_tdata[2:1]);
            seen_outcome.status     = m_axis_tdata[COUNT_W+2:3];
            seen_outcome.gate_event = event_t'(m_axis_tdata[COUNT_W+4:COUNT_W+3]);
            checked_count++;
            if (awaited_outcomes.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("%0t: result with no request pending, data %h",
                             $time, m_axis_tdata);
                end
            end else begin
                want_outcome = awaited_outcomes.pop_front();
                if (seen_outcome.granted != want_outcome.granted
                        || seen_outcome.err != want_outcome.err
                        || seen_outcome.status != want_outcome.status
                        || seen_outcome.gate_event != want_outcome.gate_event) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: expected granted %0b err %0d status %0d event %0d",
                                 $time, want_outcome.granted, want_outcome.err,
                                 want_outcome.status, want_outcome.gate_event);
                        $display("%0t:      got granted %0b err %0d status %0d event %0d",
                                 $time, seen_outcome.granted, seen_outcome.err,
                                 seen_outcome.status, seen_outcome.gate_event);
                    end
                end
            end
            if (seen_outcome.granted) grant_count++;
            if (seen_outcome.gate_event == EVENT_WAKE) wake_count++;
            if (seen_outcome.gate_event == EVENT_BLOCK) block_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Requests on a closed semaphore, and an undefined kind.
    task automatic test_closed_requests();
        write_mode(MODE_LATCH);
        issue_request(KIND_TAKE, 16'h0001, 16'h0000);
        issue_request(KIND_SET, 16'hFFFF, 16'hFFFF);
        issue_request(KIND_CLOSE, 16'h0001, 16'h0000);
        issue_request(KIND_RESET, 16'h0001, 16'h0000);
        issue_request(KIND_UNDEFINED, 16'hFFFF, 16'hFFFF);
    endtask

    // Latching rules, a second open, and the wake that a close gives.
    task automatic test_latching();
        write_mode(MODE_LATCH);
        issue_request(KIND_OPEN, 16'h0001, 16'h0000);
        issue_request(KIND_OPEN, 16'h0001, 16'h0000);
        issue_request(KIND_SET, 16'h0001, 16'h0000);
        issue_request(KIND_TAKE, 16'h0002, 16'h0000);
        issue_request(KIND_RESET, 16'h0001, 16'h0000);
        issue_request(KIND_CLOSE, 16'h0001, 16'h0000);
    endtask

    // Counting set that runs into the top of the status range.
    task automatic test_counting_saturation();
        write_mode(MODE_COUNT);
        issue_request(KIND_OPEN, 16'h0001, 16'h0000);
        issue_request(KIND_SET, 16'h0001, 16'hFFFF);
        issue_request(KIND_TAKE, 16'h0001, 16'h0000);
        issue_request(KIND_CLOSE, 16'h0001, 16'h0000);
    endtask

    // Ownership, nesting, foreign release and the refused reset of a mutex.
    task automatic test_recursive_mutex();
        write_mode(MODE_MUTEX);
        issue_request(KIND_OPEN, 16'h0001, 16'h0000);
        issue_request(KIND_TAKE, 16'h0001, 16'h0000);
        issue_request(KIND_TAKE, 16'hFFFF, 16'h0000);
        issue_request(KIND_TAKE, 16'h0001, 16'h0000);
        issue_request(KIND_SET, 16'hFFFF, 16'h0000);
        issue_request(KIND_RESET, 16'h0001, 16'h0000);
        issue_request(KIND_SET, 16'h0001, 16'h0000);
        issue_request(KIND_SET, 16'h0001, 16'h0000);
        issue_request(KIND_CLOSE, 16'h0001, 16'h0000);
    endtask

    // An undefined mode latched at open refuses take; close still works.
    task automatic test_undefined_mode();
        write_mode(MODE_UNDEFINED);
        issue_request(KIND_OPEN, 16'h0001, 16'h0000);
        issue_request(KIND_TAKE, 16'h0001, 16'h0000);
        issue_request(KIND_CLOSE, 16'h0001, 16'h0000);
    endtask

    // Random sessions under each rule set, with an occasional full pause.
    task automatic test_random_sessions();
        logic [KIND_WIDTH-1:0]   k;
        logic [ID_W-1:0]         who;
        logic [AMOUNT_WIDTH-1:0] amt;
        for (int m = MODE_LATCH; m <= MODE_MUTEX; m++) begin
            write_mode(m[MODE_WIDTH-1:0]);
            if (sem_is_open) issue_request(KIND_CLOSE, 16'h0001, 16'h0000);
            for (int n = 0; n < PER_MODE; n++) begin
                if ($urandom_range(99) < 2) drain();
                random_request(k, who, amt);
                issue_request(k, who, amt);
            end
        end
    endtask

    // The result side holds off for a long stretch while requests keep
    // coming, so the unit fills up and stops accepting.
    task automatic test_output_backpressure();
        logic [KIND_WIDTH-1:0]   k;
        logic [ID_W-1:0]         who;
        logic [AMOUNT_WIDTH-1:0] amt;
        int                      keep_send;
        int                      keep_rcv;
        keep_send = send_idle_pct;
        keep_rcv  = rcv_stall_pct;
        write_mode(MODE_COUNT);
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        if (sem_is_open) issue_request(KIND_CLOSE, 16'h0001, 16'h0000);
        stall_request = 60;
        issue_request(KIND_OPEN, 16'h0001, 16'h0000);
        repeat (40) begin
            random_request(k, who, amt);
            issue_request(k, who, amt);
        end
        drain();
        send_idle_pct = keep_send;
        rcv_stall_pct = keep_rcv;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 32;
        rcv_stall_pct = 57;
        test_closed_requests();
        test_latching();
        test_counting_saturation();
        test_recursive_mutex();
        test_undefined_mode();
        test_random_sessions();

        send_idle_pct = 57;
        rcv_stall_pct = 32;
        test_random_sessions();

        send_idle_pct = 0;
        rcv_stall_pct = 0;
        test_random_sessions();
        test_output_backpressure();

        drain();
        $display("Checked %0d results: take %0d, set %0d, reset %0d, open %0d,",
                 checked_count, kind_count[KIND_TAKE], kind_count[KIND_SET],
                 kind_count[KIND_RESET], kind_count[KIND_OPEN]);
        $display("close %0d, other %0d; mode written %0d times; %0d grants, %0d wakes,",
                 kind_count[KIND_CLOSE], kind_count[KIND_UNDEFINED], mode_writes,
                 grant_count, wake_count);
        $display("%0d blocks; %0d failures.", block_count, fail_count);
        if (fail_count == 0 && awaited_outcomes.size() == 0) begin
            $display("tb_multimode_semaphore_unit OK");
        end else begin
            $display("tb_multimode_semaphore_unit NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #3_000_000;
        $display("tb_multimode_semaphore_unit NOT OK");
        $finish;
    end

endmodule

// File: sim.f
sv/sms_pkg.sv
sv/sms_in_reg.sv
sv/sms_core.sv
sv/sms_out_reg.sv
sv/multimode_semaphore_unit.sv
bench/tb_multimode_semaphore_unit.sv
